### src/lpg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpg_pkg
// Shared types, constants and the microcode table of the permutation
// generator.
// ----------------------------------------------------------------------------
package lpg_pkg;

  localparam int VALUE_W = 5;
  localparam int POS_W   = 4;
  localparam int LEN_W   = 5;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [LEN_W-1:0] LEN_RESET  = 5'd4;
  localparam logic [0:0]       REG_LENGTH = 1'b0;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_EMIT_INIT,
    ST_EMIT_RD,
    ST_EMIT_OUT,
    ST_ADV_CHK,
    ST_FIND_RD,
    ST_FIND_CMP,
    ST_SWAP_PIV,
    ST_SWAP_K,
    ST_REV_RD,
    ST_REV_LO,
    ST_REV_HI
  } step_t;

  typedef enum logic [1:0] {WT_NONE, WT_IN_VALID, WT_OUT_READY} wait_t;

  typedef enum logic [2:0] {
    BR_NEVER,
    BR_ALWAYS,
    BR_IDX_ZERO,
    BR_A_GE_B,
    BR_IDX_NOT_LAST,
    BR_NO_NEXT,
    BR_FIND_MORE,
    BR_IDX_GE_K
  } br_t;

  typedef enum logic [2:0] {IX_HOLD, IX_LAST, IX_ZERO, IX_INC, IX_DEC, IX_PIV_P1} idx_op_t;
  typedef enum logic [1:0] {K_HOLD, K_LAST, K_DEC, K_DEC_BR} k_op_t;
  typedef enum logic [1:0] {HN_HOLD, HN_CLR, HN_LT} hn_op_t;
  typedef enum logic [1:0] {CLR_NONE, CLR_RESTART, CLR_NO_NEXT} clr_op_t;
  typedef enum logic [1:0] {RA_IDX, RA_IDX_M1, RA_K} ra_t;
  typedef enum logic [1:0] {RB_IDX, RB_PIV, RB_K} rb_t;
  typedef enum logic [1:0] {WA_IDX, WA_PIV, WA_K} wa_t;
  typedef enum logic {WD_A, WD_B} wd_t;

  typedef struct packed {
    logic    in_ready;
    logic    out_valid;
    wait_t   wait_sel;
    br_t     br_sel;
    step_t   br_target;
    idx_op_t idx_op;
    k_op_t   k_op;
    logic    piv_ld;
    hn_op_t  hn_op;
    clr_op_t clr_op;
    ra_t     ra;
    rb_t     rb;
    logic    wr_en;
    wa_t     wa;
    wd_t     wd;
  } ctrl_t;

  typedef struct packed {
    ctrl_t word;
    logic  fire;
    logic  taken;
  } seq_t;

  typedef struct packed {
    logic idx_zero;
    logic a_ge_b;
    logic idx_not_last;
    logic no_next;
    logic find_more;
    logic idx_ge_k;
  } stat_t;

  // Control store: one word per step. Fields left at zero mean "no action".
  function automatic ctrl_t ucode_word(step_t step);
    ctrl_t w;
    w = ctrl_t'('0);
    case (step)
      ST_IDLE: begin
        w.in_ready = 1'b1;
        w.wait_sel = WT_IN_VALID;
        w.idx_op   = IX_LAST;
        w.hn_op    = HN_CLR;
        w.clr_op   = CLR_RESTART;
      end
      ST_SCAN_RD: begin
        w.ra        = RA_IDX_M1;
        w.rb        = RB_IDX;
        w.br_sel    = BR_IDX_ZERO;
        w.br_target = ST_EMIT_INIT;
      end
      ST_SCAN_CMP: begin
        w.idx_op    = IX_DEC;
        w.piv_ld    = 1'b1;
        w.hn_op     = HN_LT;
        w.br_sel    = BR_A_GE_B;
        w.br_target = ST_SCAN_RD;
      end
      ST_EMIT_INIT: begin
        w.idx_op = IX_ZERO;
      end
      ST_EMIT_RD: begin
        w.ra = RA_IDX;
      end
      ST_EMIT_OUT: begin
        w.out_valid = 1'b1;
        w.wait_sel  = WT_OUT_READY;
        w.ra        = RA_IDX;
        w.idx_op    = IX_INC;
        w.br_sel    = BR_IDX_NOT_LAST;
        w.br_target = ST_EMIT_RD;
      end
      ST_ADV_CHK: begin
        w.k_op      = K_LAST;
        w.clr_op    = CLR_NO_NEXT;
        w.br_sel    = BR_NO_NEXT;
        w.br_target = ST_IDLE;
      end
      ST_FIND_RD: begin
        w.ra = RA_K;
        w.rb = RB_PIV;
      end
      ST_FIND_CMP: begin
        w.ra        = RA_K;
        w.rb        = RB_PIV;
        w.k_op      = K_DEC_BR;
        w.br_sel    = BR_FIND_MORE;
        w.br_target = ST_FIND_RD;
      end
      ST_SWAP_PIV: begin
        w.ra    = RA_K;
        w.rb    = RB_PIV;
        w.wr_en = 1'b1;
        w.wa    = WA_PIV;
        w.wd    = WD_A;
      end
      ST_SWAP_K: begin
        w.wr_en  = 1'b1;
        w.wa     = WA_K;
        w.wd     = WD_B;
        w.idx_op = IX_PIV_P1;
        w.k_op   = K_LAST;
      end
      ST_REV_RD: begin
        w.ra        = RA_IDX;
        w.rb        = RB_K;
        w.br_sel    = BR_IDX_GE_K;
        w.br_target = ST_IDLE;
      end
      ST_REV_LO: begin
        w.ra    = RA_IDX;
        w.rb    = RB_K;
        w.wr_en = 1'b1;
        w.wa    = WA_IDX;
        w.wd    = WD_B;
      end
      ST_REV_HI: begin
        w.wr_en     = 1'b1;
        w.wa        = WA_K;
        w.wd        = WD_A;
        w.idx_op    = IX_INC;
        w.k_op      = K_DEC;
        w.br_sel    = BR_ALWAYS;
        w.br_target = ST_REV_RD;
      end
      default: begin
        w.br_sel    = BR_ALWAYS;
        w.br_target = ST_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

### src/lpg_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpg_ifs
// Request and response channel interfaces of the permutation generator.
// ----------------------------------------------------------------------------
interface lpg_req_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface lpg_rsp_if import lpg_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;
  logic [POS_W-1:0]   position;
  logic               last_of_run;
  logic               final_permutation;

  modport source (output valid, output value, output position, output last_of_run,
                  output final_permutation, input ready);
  modport sink   (input valid, input value, input position, input last_of_run,
                  input final_permutation, output ready);
endinterface

### src/lexicographic_permutation_generator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lexicographic_permutation_generator_top
// Emits the current arrangement of 1..length one element per beat, then
// steps it to the next permutation in lexicographic order.
//
//   channel  dir  handshake        payload
//   req      in   valid / ready    restart
//   rsp      out  valid / ready    value, position, last_of_run,
//                                  final_permutation
//   apb      in   psel & penable   length (register 0, byte address 0)
//
// One request is handled at a time by a microcoded sequencer driving a store
// with two read ports and one write port. For n elements, a request scans
// adjacent pairs for the pivot, emits the n elements, searches the swap
// partner, swaps it with the pivot and reverses the suffix; after the last
// permutation the identity is reloaded instead. Reset and a length write
// reload the identity via valid bits. A stalled rsp beat holds the
// sequencer; req.ready is high only between requests.
// ----------------------------------------------------------------------------
module lexicographic_permutation_generator_top import lpg_pkg::*; #(
  parameter int MAX_LEN = 16
) (
  input  logic               clk,
  input  logic               rst,
  lpg_req_if.sink            req,
  lpg_rsp_if.source          rsp,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int W_IDX  = $clog2(MAX_LEN);
  localparam int W_VALX = $clog2(MAX_LEN + 1);
  localparam int W_LEN  = (W_VALX > LEN_W) ? W_VALX : LEN_W;

  logic [LEN_W-1:0] length;
  logic             cfg_wr;
  logic [W_LEN-1:0] len_ext;
  logic [W_LEN-1:0] last_ext;
  logic [W_IDX-1:0] last;
  seq_t             seq;
  stat_t            stat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[PADDR_W-1:2] == REG_LENGTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      length <= LEN_RESET;
    end else if (cfg_wr) begin
      length <= pwdata[LEN_W-1:0];
    end
  end

  always_comb begin
    case (paddr[PADDR_W-1:2])
      REG_LENGTH: prdata = PDATA_W'(length);
      default:    prdata = '0;
    endcase
  end

  // zero counts as one element, anything above MAX_LEN saturates
  always_comb begin
    len_ext = W_LEN'(length);
    if (len_ext == '0) begin
      last_ext = '0;
    end else if (len_ext > W_LEN'(MAX_LEN)) begin
      last_ext = W_LEN'(MAX_LEN - 1);
    end else begin
      last_ext = len_ext - W_LEN'(1);
    end
    last = last_ext[W_IDX-1:0];
  end

  lpg_sequencer u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .out_ready (rsp.ready),
    .stat      (stat),
    .seq       (seq)
  );

  lpg_datapath #(
    .MAX_LEN (MAX_LEN)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .seq               (seq),
    .restart           (req.restart),
    .cfg_clear         (cfg_wr),
    .last              (last),
    .stat              (stat),
    .value             (rsp.value),
    .position          (rsp.position),
    .last_of_run       (rsp.last_of_run),
    .final_permutation (rsp.final_permutation)
  );

  assign req.ready = seq.word.in_ready;
  assign rsp.valid = seq.word.out_valid;

endmodule

### src/lpg_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpg_sequencer
// Step counter over the microcode table, with wait and branch evaluation.
// ----------------------------------------------------------------------------
module lpg_sequencer import lpg_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output seq_t  seq
);

  step_t upc;
  step_t upc_next;
  ctrl_t word;
  logic  fire;
  logic  taken;

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= ST_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

  always_comb begin
    word = ucode_word(upc);

    case (word.wait_sel)
      WT_NONE:      fire = 1'b1;
      WT_IN_VALID:  fire = in_valid;
      WT_OUT_READY: fire = out_ready;
      default:      fire = 1'b0;
    endcase

    case (word.br_sel)
      BR_NEVER:        taken = 1'b0;
      BR_ALWAYS:       taken = 1'b1;
      BR_IDX_ZERO:     taken = stat.idx_zero;
      BR_A_GE_B:       taken = stat.a_ge_b;
      BR_IDX_NOT_LAST: taken = stat.idx_not_last;
      BR_NO_NEXT:      taken = stat.no_next;
      BR_FIND_MORE:    taken = stat.find_more;
      BR_IDX_GE_K:     taken = stat.idx_ge_k;
      default:         taken = 1'b0;
    endcase

    // hold the step while its wait condition is false
    upc_next = upc;
    if (fire) begin
      upc_next = taken ? word.br_target : step_t'(upc + 4'd1);
    end

    seq.word  = word;
    seq.fire  = fire;
    seq.taken = taken;
  end

endmodule

### src/lpg_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpg_datapath
// Arrangement store (two read ports, one write port) and the index, pivot
// and flag registers that the microcode steers.
// ----------------------------------------------------------------------------
module lpg_datapath import lpg_pkg::*; #(
  parameter int MAX_LEN = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  seq_t                       seq,
  input  logic                       restart,
  input  logic                       cfg_clear,
  input  logic [$clog2(MAX_LEN)-1:0] last,
  output stat_t                      stat,
  output logic [VALUE_W-1:0]         value,
  output logic [POS_W-1:0]           position,
  output logic                       last_of_run,
  output logic                       final_permutation
);

  localparam int W_IDX = $clog2(MAX_LEN);
  localparam int W_VAL = $clog2(MAX_LEN + 1);
  localparam int DEPTH = 1 << W_IDX;

  logic [W_VAL-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid;

  logic [W_IDX-1:0] idx;
  logic [W_IDX-1:0] k;
  logic [W_IDX-1:0] piv;
  logic             hn;
  logic [W_VAL-1:0] rd_a;
  logic [W_VAL-1:0] rd_b;

  logic [W_IDX-1:0] ra_addr;
  logic [W_IDX-1:0] rb_addr;
  logic [W_IDX-1:0] wr_addr;
  logic [W_VAL-1:0] wr_data;
  logic             wr;
  logic             clr;
  logic             a_lt_b;

  logic [W_VAL+VALUE_W-1:0] value_ext;
  logic [W_IDX+POS_W-1:0]   pos_ext;

  ctrl_t w;

  always_comb begin
    w = seq.word;

    case (w.ra)
      RA_IDX:    ra_addr = idx;
      RA_IDX_M1: ra_addr = idx - W_IDX'(1);
      RA_K:      ra_addr = k;
      default:   ra_addr = idx;
    endcase

    case (w.rb)
      RB_IDX:  rb_addr = idx;
      RB_PIV:  rb_addr = piv;
      RB_K:    rb_addr = k;
      default: rb_addr = idx;
    endcase

    case (w.wa)
      WA_IDX:  wr_addr = idx;
      WA_PIV:  wr_addr = piv;
      WA_K:    wr_addr = k;
      default: wr_addr = idx;
    endcase

    wr_data = (w.wd == WD_B) ? rd_b : rd_a;
    wr      = seq.fire && w.wr_en;
    a_lt_b  = rd_a < rd_b;

    // drop the whole arrangement back to the identity
    clr = cfg_clear ||
          (seq.fire && w.clr_op == CLR_RESTART && restart) ||
          (seq.fire && w.clr_op == CLR_NO_NEXT && !hn);
  end

  // an entry without its valid bit reads as the identity value addr+1
  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a <= valid[ra_addr] ? mem[ra_addr] : W_VAL'(ra_addr) + W_VAL'(1);
    rd_b <= valid[rb_addr] ? mem[rb_addr] : W_VAL'(rb_addr) + W_VAL'(1);
  end

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      valid <= '0;
    end else if (wr) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (seq.fire) begin
      case (w.idx_op)
        IX_LAST:   idx <= last;
        IX_ZERO:   idx <= '0;
        IX_INC:    idx <= idx + W_IDX'(1);
        IX_DEC:    idx <= idx - W_IDX'(1);
        IX_PIV_P1: idx <= piv + W_IDX'(1);
        default:   idx <= idx;
      endcase

      case (w.k_op)
        K_LAST:   k <= last;
        K_DEC:    k <= k - W_IDX'(1);
        K_DEC_BR: k <= seq.taken ? k - W_IDX'(1) : k;
        default:  k <= k;
      endcase

      if (w.piv_ld) begin
        piv <= idx - W_IDX'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hn <= 1'b0;
    end else if (seq.fire) begin
      case (w.hn_op)
        HN_CLR:  hn <= 1'b0;
        HN_LT:   hn <= a_lt_b;
        default: hn <= hn;
      endcase
    end
  end

  always_comb begin
    stat.idx_zero     = (idx == '0);
    stat.a_ge_b       = !a_lt_b;
    stat.idx_not_last = (idx != last);
    stat.no_next      = !hn;
    stat.find_more    = (k > piv) && (rd_a <= rd_b);
    stat.idx_ge_k     = (idx >= k);

    value_ext         = {{VALUE_W{1'b0}}, rd_a};
    pos_ext           = {{POS_W{1'b0}}, idx};
    value             = value_ext[VALUE_W-1:0];
    position          = pos_ext[POS_W-1:0];
    last_of_run       = (idx == last);
    final_permutation = !hn;
  end

endmodule

### src/lpg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpg_checker
// Port-level checks of the permutation generator, bound to the top level.
// ----------------------------------------------------------------------------
module lpg_checker import lpg_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_ready,
  input logic               rsp_valid,
  input logic               rsp_ready,
  input logic [VALUE_W-1:0] rsp_value,
  input logic [POS_W-1:0]   rsp_position,
  input logic               rsp_last_of_run
);

  logic [POS_W-1:0] pos_exp;

  // track the position the next beat must carry
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_exp <= '0;
    end else if (rsp_valid && rsp_ready) begin
      pos_exp <= rsp_last_of_run ? '0 : pos_exp + POS_W'(1);
    end
  end

  a_reset_idle: assert property (@(posedge clk)
    rst |=> req_ready && !rsp_valid)
    else $error("not idle after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while another is in flight");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !req_ready)
    else $error("ready for a request while a beat is pending");

  a_position_order: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_position == pos_exp)
    else $error("beat position out of order");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value) && $stable(rsp_position))
    else $error("stalled beat changed");

endmodule

bind lexicographic_permutation_generator_top lpg_checker u_chk (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_value       (rsp.value),
  .rsp_position    (rsp.position),
  .rsp_last_of_run (rsp.last_of_run)
);

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the lexicographic permutation generator. Requests go in on the
// req channel. Every beat on the rsp channel is checked against a permutation
// predictor kept in the bench. The length register is written over APB
// between phases, covering zero, one, the largest length and values above it.
// Sender gaps and receiver stalls vary from phase to phase.
// ----------------------------------------------------------------------------
module tb_top;
  import lpg_pkg::*;

  localparam int MAX_LEN      = 16;
  localparam int SETTLE_CYC   = 100;  // covers the advance pass after the last beat
  localparam int TIMEOUT_NS   = 20_000_000;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [POS_W-1:0]   position;
    logic               last_of_run;
    logic               final_permutation;
  } perm_beat_t;

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  lpg_req_if req_ch();
  lpg_rsp_if rsp_ch();

  lexicographic_permutation_generator_top #(.MAX_LEN(MAX_LEN)) DUT (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predictor state
  logic [VALUE_W-1:0] perm_state [MAX_LEN];
  logic [LEN_W-1:0]   length_reg;
  perm_beat_t         expected_beats [$];

  int unsigned tx_idle_pct;
  int unsigned rx_stall_pct;
  int unsigned rx_hold_cnt;
  int unsigned error_cnt;

  perm_beat_t got_beat;
  perm_beat_t exp_beat;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("FAIL lexicographic_permutation_generator_top");
    $finish;
  end

  function automatic void load_identity_perm();
    for (int i = 0; i < MAX_LEN; i++) perm_state[i] = VALUE_W'(i + 1);
  endfunction

  // Queue the beats of one request, then step the arrangement.
  function automatic void predict_permutation(input bit restart_bit);
    int         n;
    int         piv;
    int         k;
    int         lo;
    int         hi;
    bit         has_next;
    logic [VALUE_W-1:0] t;
    perm_beat_t beat;
    n = (length_reg == 0) ? 1 : ((length_reg > MAX_LEN) ? MAX_LEN : int'(length_reg));
    if (restart_bit) load_identity_perm();
    has_next = 1'b0;
    piv = 0;
    for (int i = n - 1; i > 0; i--) begin
      if (!has_next && perm_state[i-1] < perm_state[i]) begin
        has_next = 1'b1;
        piv = i - 1;
      end
    end
    for (int i = 0; i < n; i++) begin
      beat.value             = perm_state[i];
      beat.position          = POS_W'(i);
      beat.last_of_run       = (i == n - 1);
      beat.final_permutation = !has_next;
      expected_beats.push_back(beat);
    end
    if (has_next) begin
      k = n - 1;
      while (k > piv && perm_state[k] <= perm_state[piv]) k--;
      t = perm_state[piv];
      perm_state[piv] = perm_state[k];
      perm_state[k] = t;
      lo = piv + 1;
      hi = n - 1;
      while (lo < hi) begin
        t = perm_state[lo];
        perm_state[lo] = perm_state[hi];
        perm_state[hi] = t;
        lo++;
        hi--;
      end
    end else begin
      load_identity_perm();
    end
  endfunction

  // receiver: long hold-off takes priority over random stalls
  always @(posedge clk) begin
    if (rx_hold_cnt > 0) begin
      rsp_ch.ready <= 1'b0;
      rx_hold_cnt = rx_hold_cnt - 1;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got_beat.value             = rsp_ch.value;
      got_beat.position          = rsp_ch.position;
      got_beat.last_of_run       = rsp_ch.last_of_run;
      got_beat.final_permutation = rsp_ch.final_permutation;
      if (expected_beats.size() == 0) begin
        error_cnt++;
        $display("%0t: unexpected beat value=%0d position=%0d last=%0b final=%0b",
                 $time, got_beat.value, got_beat.position, got_beat.last_of_run,
                 got_beat.final_permutation);
      end else begin
        exp_beat = expected_beats.pop_front();
        if (got_beat !== exp_beat) begin
          error_cnt++;
          $display("%0t: mismatch expected value=%0d position=%0d last=%0b final=%0b",
                   $time, exp_beat.value, exp_beat.position, exp_beat.last_of_run,
                   exp_beat.final_permutation);
          $display("%0t:          actual   value=%0d position=%0d last=%0b final=%0b",
                   $time, got_beat.value, got_beat.position, got_beat.last_of_run,
                   got_beat.final_permutation);
        end
      end
    end
  end

  task automatic send_request(input bit restart_bit);
    @(posedge clk);
    while ($urandom_range(99) < tx_idle_pct) @(posedge clk);
    req_ch.valid   <= 1'b1;
    req_ch.restart <= restart_bit;
    do @(posedge clk); while (!req_ch.ready);
    req_ch.valid <= 1'b0;
    predict_permutation(restart_bit);
  endtask

  task automatic wait_drained();
    while (expected_beats.size() != 0) @(posedge clk);
  endtask

  task automatic write_length(input logic [LEN_W-1:0] len);
    wait_drained();
    repeat (SETTLE_CYC) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(int'(REG_LENGTH) * 4);
    pwdata  <= ($urandom() & ~32'h1F) | PDATA_W'(len);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    length_reg = len;
    load_identity_perm();
  endtask

  task automatic run_random_requests(input int cnt, input int unsigned restart_pct);
    for (int i = 0; i < cnt; i++) send_request($urandom_range(99) < restart_pct);
  endtask

  task automatic set_idling(input int unsigned tx_pct, input int unsigned rx_pct);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
  endtask

  task automatic test_directed_edges();
    set_idling(0, 0);
    // reset length, then restart mid-sequence
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b1);
    send_request(1'b0);
    // single element is first and last at once
    write_length(5'd1);
    send_request(1'b0);
    send_request(1'b1);
    write_length(5'd2);
    repeat (3) send_request(1'b0);
    // full cycle of six plus the wrap to identity
    write_length(5'd3);
    repeat (7) send_request(1'b0);
    // zero acts as one
    write_length(5'd0);
    repeat (2) send_request(1'b0);
    // above the maximum saturates
    write_length(5'd31);
    send_request(1'b0);
    write_length(5'd17);
    send_request(1'b1);
    write_length(5'd16);
    send_request(1'b1);
  endtask

  task automatic test_random_no_idle();
    set_idling(0, 0);
    write_length(5'd4);
    // rare restarts so the sequence can wrap
    run_random_requests(45, 3);
  endtask

  task automatic test_random_sender_gaps();
    set_idling(70, 0);
    write_length(5'd3);
    run_random_requests(30, 15);
  endtask

  task automatic test_random_receiver_stalls();
    set_idling(0, 70);
    write_length(5'd5);
    run_random_requests(30, 10);
  endtask

  task automatic test_random_mixed();
    set_idling(16, 16);
    for (int p = 0; p < 4; p++) begin
      if ($urandom_range(3) == 0) write_length(LEN_W'($urandom_range(0, 31)));
      else write_length(LEN_W'($urandom_range(1, 8)));
      run_random_requests(10, 15);
    end
  endtask

  task automatic test_backpressure_hold();
    set_idling(0, 0);
    write_length(5'd6);
    // hold the receiver while requests keep coming
    rx_hold_cnt = 400;
    run_random_requests(4, 20);
    // pause the sender until every beat is out
    wait_drained();
    run_random_requests(5, 20);
  endtask

  task automatic test_full_length();
    set_idling(16, 16);
    write_length(5'd16);
    run_random_requests(5, 20);
  endtask

  initial begin
    rst            = 1'b1;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    req_ch.valid   = 1'b0;
    req_ch.restart = 1'b0;
    rsp_ch.ready   = 1'b0;
    tx_idle_pct    = 0;
    rx_stall_pct   = 0;
    rx_hold_cnt    = 0;
    error_cnt      = 0;
    length_reg     = LEN_RESET;
    load_identity_perm();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_edges();
    test_random_no_idle();
    test_random_sender_gaps();
    test_random_receiver_stalls();
    test_random_mixed();
    test_backpressure_hold();
    test_full_length();

    wait_drained();
    repeat (SETTLE_CYC) @(posedge clk);
    if (error_cnt == 0) begin
      $display("PASS lexicographic_permutation_generator_top");
    end else begin
      $display("FAIL lexicographic_permutation_generator_top");
    end
    $finish;
  end

endmodule
